/* sv/ptc_pkg.sv */
// Shared types, codes and the permission check for the page table unit.
// No dependencies; imported by ptc_cell and page_table_translate_check_unit.
package ptc_pkg;

	localparam int VA_W    = 32;
	localparam int FRAME_W = 32;
	localparam int PA_W    = 32;
	localparam int PERM_W  = 3;
	localparam int ACC_W   = 2;
	localparam int STAT_W  = 3;

	localparam logic OP_MAP     = 1'b0;
	localparam logic OP_RESOLVE = 1'b1;

	localparam logic [ACC_W-1:0] ACC_NONE  = 2'd0;
	localparam logic [ACC_W-1:0] ACC_READ  = 2'd1;
	localparam logic [ACC_W-1:0] ACC_WRITE = 2'd2;
	localparam logic [ACC_W-1:0] ACC_EXEC  = 2'd3;

	localparam int PERM_READ_BIT  = 0;
	localparam int PERM_WRITE_BIT = 1;
	localparam int PERM_EXEC_BIT  = 2;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOEXEC  = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOREAD  = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOWRITE = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic               op;
		logic [VA_W-1:0]    vaddr;
		logic [PERM_W-1:0]  page_perms;
		logic [ACC_W-1:0]   required_access;
		logic [FRAME_W-1:0] frame_base;
	} req_item_t;

	typedef struct packed {
		logic              found;
		logic [PA_W-1:0]   paddr;
		logic [STAT_W-1:0] status;
	} rsp_item_t;

	// Lookup that walks down the row of cells
	typedef struct packed {
		logic [VA_W-1:0]  va;
		logic [ACC_W-1:0] access;
	} ptc_query_t;

	// Append broadcast to every cell; the cell at the fill index takes it
	typedef struct packed {
		logic               en;
		logic [VA_W-1:0]    va;
		logic [PERM_W-1:0]  perms;
		logic [FRAME_W-1:0] frame;
	} ptc_map_t;

	function automatic logic [STAT_W-1:0] access_status(
		input logic [PERM_W-1:0] perms,
		input logic [ACC_W-1:0]  access
	);
		logic [STAT_W-1:0] st;
		st = ST_OK;
		case (access)
			ACC_EXEC: begin
				// missing read wins over missing exec
				if (!perms[PERM_EXEC_BIT]) st = ST_NOEXEC;
				if (!perms[PERM_READ_BIT]) st = ST_NOREAD;
			end
			ACC_READ: begin
				if (!perms[PERM_READ_BIT]) st = ST_NOREAD;
			end
			ACC_WRITE: begin
				if (!perms[PERM_WRITE_BIT]) st = ST_NOWRITE;
			end
			default: begin
				st = ST_OK;
			end
		endcase
		return st;
	endfunction

endpackage

/* sv/page_table_translate_check_unit.sv */
// Fully associative page table with permission check, built as a row of entry cells.
// Map: result ready the cycle after the transfer; the next transfer can follow at once
// unless the response is stalled. Resolve: the lookup walks one cell per cycle and stops
// at a hit, at the first empty entry or at the last cell; the next transfer waits for it.
// Reset clears the entry count and all handshake state; entry contents are undefined.
// Depends on ptc_pkg and ptc_cell.
module page_table_translate_check_unit #(
	parameter int ENTRIES          = 64,
	parameter int PAGE_OFFSET_BITS = 12,
	parameter int ADDR_BITS        = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ptc_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ptc_pkg::rsp_item_t  rsp
);
	import ptc_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [CNT_W-1:0]   count_q;
	logic               busy_q;
	logic               out_valid_q;
	rsp_item_t          out_q;

	logic               accept;
	logic               take;
	logic               full;
	logic               launch;
	ptc_map_t           map;

	logic               tok_v [ENTRIES];
	ptc_query_t         tok   [ENTRIES];
	logic [ENTRIES-1:0] res_v;
	rsp_item_t          res   [ENTRIES];
	logic               any_res;
	rsp_item_t          res_or;

	assign accept    = req_valid && !req_stall;
	assign take      = rsp_valid && !rsp_stall;
	assign req_stall = busy_q || (out_valid_q && rsp_stall);
	assign full      = count_q == CNT_W'(ENTRIES);
	assign launch    = accept && req.op == OP_RESOLVE;

	always_comb begin
		map.en    = accept && req.op == OP_MAP && !full;
		map.va    = req.vaddr;
		map.perms = req.page_perms;
		map.frame = req.frame_base;
	end

	assign tok_v[0] = launch;
	assign tok[0]   = '{va: req.vaddr, access: req.required_access};

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == ENTRIES - 1) begin : g_last
			ptc_cell #(
				.CNT_W(CNT_W), .IDX(i), .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS),
				.ADDR_BITS(ADDR_BITS), .LAST(1'b1)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .count(count_q), .map(map),
				.tok_valid_in(tok_v[i]), .tok_in(tok[i]),
				.tok_valid_out(), .tok_out(),
				.res_valid(res_v[i]), .res(res[i])
			);
		end else begin : g_mid
			ptc_cell #(
				.CNT_W(CNT_W), .IDX(i), .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS),
				.ADDR_BITS(ADDR_BITS), .LAST(1'b0)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .count(count_q), .map(map),
				.tok_valid_in(tok_v[i]), .tok_in(tok[i]),
				.tok_valid_out(tok_v[i+1]), .tok_out(tok[i+1]),
				.res_valid(res_v[i]), .res(res[i])
			);
		end
	end

	// At most one cell reports per cycle, so an AND-OR gather selects it
	always_comb begin
		res_or = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			res_or = res_or | (res_v[i] ? res[i] : '0);
		end
		any_res = |res_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (map.en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (launch) begin
				busy_q <= 1'b1;
			end else if (any_res) begin
				busy_q <= 1'b0;
			end
			if ((accept && req.op == OP_MAP) || any_res) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.op == OP_MAP) begin
			out_q.found  <= !full;
			out_q.paddr  <= '0;
			out_q.status <= full ? ST_FULL : ST_OK;
		end else if (any_res) begin
			out_q <= res_or;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A lookup in flight always finds the output register empty
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> !out_valid_q)
		else $error("output register occupied while a lookup walks the row");

	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(res_v))
		else $error("more than one cell reported in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n) any_res |-> busy_q)
		else $error("cell reported with no lookup in flight");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

endmodule

/* sv/ptc_cell.sv */
// One table entry plus one stage of the lookup chain.
// Depends on ptc_pkg; instantiated in a row by page_table_translate_check_unit.
module ptc_cell #(
	parameter int CNT_W            = 7,
	parameter int IDX              = 0,
	parameter int PAGE_OFFSET_BITS = 12,
	parameter int ADDR_BITS        = 32,
	parameter bit LAST             = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CNT_W-1:0]      count,
	input  ptc_pkg::ptc_map_t     map,
	input  logic                  tok_valid_in,
	input  ptc_pkg::ptc_query_t   tok_in,
	output logic                  tok_valid_out,
	output ptc_pkg::ptc_query_t   tok_out,
	output logic                  res_valid,
	output ptc_pkg::rsp_item_t    res
);
	import ptc_pkg::*;

	localparam int PAGE_W = VA_W - PAGE_OFFSET_BITS;
	localparam logic [PA_W-1:0] PA_MASK = (ADDR_BITS >= PA_W) ? {PA_W{1'b1}} :
		PA_W'((64'd1 << ADDR_BITS) - 64'd1);

	logic [PAGE_W-1:0]  page_q;
	logic [PERM_W-1:0]  perms_q;
	logic [FRAME_W-1:0] frame_q;

	logic               tok_valid_q;
	ptc_query_t         tok_q;
	logic               res_valid_q;
	rsp_item_t          res_q;

	logic               in_use;
	logic               match;
	logic               stop;
	logic [PA_W-1:0]    sum;
	rsp_item_t          res_d;

	always_ff @(posedge clk) begin
		if (map.en && count == CNT_W'(IDX)) begin
			page_q  <= map.va[VA_W-1:PAGE_OFFSET_BITS];
			perms_q <= map.perms;
			frame_q <= map.frame;
		end
	end

	always_comb begin
		in_use = count > CNT_W'(IDX);
		match  = in_use && (page_q == tok_q.va[VA_W-1:PAGE_OFFSET_BITS]);
		// end the walk on a hit, past the last filled entry, or at the row's end
		stop   = !in_use || match || LAST;
		sum    = frame_q + {{(PA_W-PAGE_OFFSET_BITS){1'b0}}, tok_q.va[PAGE_OFFSET_BITS-1:0]};
		res_d.found  = match;
		res_d.paddr  = match ? (sum & PA_MASK) : '0;
		res_d.status = match ? access_status(perms_q, tok_q.access) : ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_valid_in;
			res_valid_q <= tok_valid_q && stop;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_valid_in) begin
			tok_q <= tok_in;
		end
		if (tok_valid_q && stop) begin
			res_q <= res_d;
		end
	end

	assign tok_valid_out = tok_valid_q && !stop;
	assign tok_out       = tok_q;
	assign res_valid     = res_valid_q;
	assign res           = res_q;

endmodule
